FILE: rtl/gtlo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlo_pkg
// Shared types, constants and tables for the GPS to local offset unit.
// ----------------------------------------------------------------------------
package gtlo_pkg;

  // Default configuration of the cosine unit.
  localparam int unsigned COS_FRAC_BITS_DEF = 16;
  localparam int unsigned CORDIC_STEPS_DEF  = 18;

  // Request function codes.
  localparam logic [1:0] FUNC_CUR  = 2'd0;
  localparam logic [1:0] FUNC_TGT  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_DEADBAND = 2'd1;

  localparam logic [22:0] RADIUS_RESET   = 23'd6371000;
  localparam logic [9:0]  DEADBAND_RESET = 10'd6;

  // Fixed-point constants.
  localparam logic [31:0] KQ_MM       = 32'd1965066036;  // pi/180 * 1e-4 * 2^50
  localparam logic [31:0] DEG_TO_RAD  = 32'd4024455254;  // 1e-7 deg to Q30 rad, 2^-31
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] QUARTER_E7  = 31'd900000000;
  localparam logic [30:0] HALF_E7     = 31'd1800000000;

  // Width of the rounded offset magnitudes.
  localparam int unsigned MAG_W = 38;
  localparam int unsigned ACC_W = 88;

  // Micro-operation sequence over the shared multiplier.
  localparam logic [3:0] OP_ANGLE = 4'd0;
  localparam logic [3:0] OP_LAST  = 4'd8;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_ACC, S_CORDIC, S_COS, S_FIN
  } state_e;

  typedef enum logic [2:0] {
    A_LAT, A_RAD, A_TLO, A_THI, A_E1LO, A_E1HI
  } a_sel_e;

  typedef enum logic [2:0] {
    B_DEG, B_DLAT, B_DLON, B_KQ, B_COS
  } b_sel_e;

  typedef enum logic [1:0] {
    RND_NONE, RND_31, RND_50, RND_F
  } rnd_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_Z, DST_T, DST_N, DST_E1, DST_EM
  } dst_e;

  typedef struct packed {
    a_sel_e a;
    b_sel_e b;
    logic   clr;
    logic   hi;
    rnd_e   rnd;
    dst_e   dst;
  } op_desc_t;

  typedef struct packed {
    logic     take;
    logic     load;
    logic     mul_en;
    logic     acc_en;
    op_desc_t op;
    logic     cordic_step;
    logic [4:0] step;
    logic     cos_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic out_free;
    logic pending;
  } stat_t;

  // Description of each multiply-accumulate step.
  function automatic op_desc_t op_desc(input logic [3:0] idx);
    op_desc_t d;
    d = '{a: A_LAT, b: B_DEG, clr: 1'b1, hi: 1'b0, rnd: RND_NONE, dst: DST_NONE};
    unique case (idx)
      4'd0: d = '{a: A_LAT,  b: B_DEG,  clr: 1'b1, hi: 1'b0, rnd: RND_31,   dst: DST_Z};
      4'd1: d = '{a: A_RAD,  b: B_DLAT, clr: 1'b1, hi: 1'b0, rnd: RND_NONE, dst: DST_T};
      4'd2: d = '{a: A_TLO,  b: B_KQ,   clr: 1'b1, hi: 1'b0, rnd: RND_50,   dst: DST_NONE};
      4'd3: d = '{a: A_THI,  b: B_KQ,   clr: 1'b0, hi: 1'b1, rnd: RND_NONE, dst: DST_N};
      4'd4: d = '{a: A_RAD,  b: B_DLON, clr: 1'b1, hi: 1'b0, rnd: RND_NONE, dst: DST_T};
      4'd5: d = '{a: A_TLO,  b: B_KQ,   clr: 1'b1, hi: 1'b0, rnd: RND_50,   dst: DST_NONE};
      4'd6: d = '{a: A_THI,  b: B_KQ,   clr: 1'b0, hi: 1'b1, rnd: RND_NONE, dst: DST_E1};
      4'd7: d = '{a: A_E1LO, b: B_COS,  clr: 1'b1, hi: 1'b0, rnd: RND_F,    dst: DST_NONE};
      4'd8: d = '{a: A_E1HI, b: B_COS,  clr: 1'b0, hi: 1'b1, rnd: RND_NONE, dst: DST_EM};
      default: d = '{a: A_LAT, b: B_DEG, clr: 1'b1, hi: 1'b0, rnd: RND_NONE, dst: DST_NONE};
    endcase
    return d;
  endfunction

  // Truncated Q30 arctangent table for the CORDIC rotation.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    v = 32'h0;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Saturate a magnitude with sign to the 36-bit signed range.
  function automatic logic [35:0] sat36(input logic [MAG_W-1:0] mag, input logic neg);
    logic big;
    logic [35:0] r;
    big = |mag[MAG_W-1:35];
    if (neg) begin
      r = big ? 36'h800000000 : (36'd0 - mag[35:0]);
    end else begin
      r = big ? 36'h7FFFFFFFF : mag[35:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/gtlo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlo_ctrl
// Sequencer: walks an armed tick through angle, CORDIC and multiply steps.
// ----------------------------------------------------------------------------
module gtlo_ctrl #(
  parameter int unsigned CORDIC_STEPS = gtlo_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gtlo_pkg::stat_t stat_i,
  output gtlo_pkg::cmd_t  cmd_o
);

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  gtlo_pkg::state_e state_q, state_d;
  logic [3:0] op_q, op_d;
  logic [4:0] step_q, step_d;

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtlo_pkg::S_IDLE;
      op_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.op   = gtlo_pkg::op_desc(op_q);
    cmd_o.step = step_q;
    unique case (state_q)
      gtlo_pkg::S_IDLE: begin
        cmd_o.take = 1'b1;
        if (stat_i.tick_go) begin
          state_d = gtlo_pkg::S_LOAD;
        end
      end
      gtlo_pkg::S_LOAD: begin
        cmd_o.load = 1'b1;
        op_d    = gtlo_pkg::OP_ANGLE;
        state_d = gtlo_pkg::S_MUL;
      end
      gtlo_pkg::S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = gtlo_pkg::S_ACC;
      end
      gtlo_pkg::S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (op_q == gtlo_pkg::OP_ANGLE) begin
          step_d  = '0;
          state_d = gtlo_pkg::S_CORDIC;
        end else if (op_q == gtlo_pkg::OP_LAST) begin
          state_d = gtlo_pkg::S_FIN;
        end else begin
          op_d    = op_q + 4'd1;
          state_d = gtlo_pkg::S_MUL;
        end
      end
      gtlo_pkg::S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = gtlo_pkg::S_COS;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      gtlo_pkg::S_COS: begin
        cmd_o.cos_load = 1'b1;
        op_d    = op_q + 4'd1;
        state_d = gtlo_pkg::S_MUL;
      end
      gtlo_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = gtlo_pkg::S_IDLE;
        end
      end
      default: state_d = gtlo_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/gtlo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtlo_dp
// Datapath: position state, shared multiplier and accumulator, CORDIC, output.
// ----------------------------------------------------------------------------
module gtlo_dp #(
  parameter int unsigned COS_FRAC_BITS = gtlo_pkg::COS_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtlo_pkg::cmd_t     cmd_i,
  output gtlo_pkg::stat_t    stat_o,
  input  logic               in_valid_i,
  input  logic [1:0]         func_i,
  input  logic signed [30:0] lat_e7_i,
  input  logic signed [31:0] lon_e7_i,
  input  logic signed [31:0] alt_mm_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [22:0]        cfg_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [35:0] north_mm_o,
  output logic signed [35:0] east_mm_o,
  output logic signed [33:0] down_mm_o
);

  localparam int unsigned SH   = 30 - COS_FRAC_BITS;
  localparam int unsigned CM_W = COS_FRAC_BITS + 1;
  localparam int unsigned MW   = gtlo_pkg::MAG_W;
  localparam int unsigned AW   = gtlo_pkg::ACC_W;
  localparam logic signed [33:0] COS_RND = 34'((2 ** SH) / 2);
  localparam logic signed [33:0] COS_ONE = 34'(2 ** COS_FRAC_BITS);
  localparam logic [AW-1:0] RND31 = {{(AW-1){1'b0}}, 1'b1} << 30;
  localparam logic [AW-1:0] RND50 = {{(AW-1){1'b0}}, 1'b1} << 49;
  localparam logic [AW-1:0] RNDF  = {{(AW-1){1'b0}}, 1'b1} << (COS_FRAC_BITS - 1);

  // Configuration registers.
  logic [22:0] radius_q;
  logic [9:0]  db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gtlo_pkg::RADIUS_RESET;
      db_q     <= gtlo_pkg::DEADBAND_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gtlo_pkg::CFG_RADIUS) begin
        radius_q <= cfg_data_i;
      end else if (cfg_idx_i == gtlo_pkg::CFG_DEADBAND) begin
        db_q <= cfg_data_i[9:0];
      end
    end
  end

  // Position state, updated by accepted requests.
  logic signed [30:0] cur_lat_q, tgt_lat_q;
  logic signed [31:0] cur_lon_q, tgt_lon_q, home_q, tgt_alt_q;
  logic signed [32:0] rel_alt_q;
  logic               pending_q;
  logic               in_acc;

  assign in_acc = in_valid_i & cmd_i.take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_lat_q <= '0;
      cur_lon_q <= '0;
      rel_alt_q <= '0;
      home_q    <= '0;
      tgt_lat_q <= '0;
      tgt_lon_q <= '0;
      tgt_alt_q <= '0;
      pending_q <= 1'b0;
    end else if (in_acc) begin
      unique case (func_i)
        gtlo_pkg::FUNC_CUR: begin
          cur_lat_q <= lat_e7_i;
          cur_lon_q <= lon_e7_i;
          if (home_q == '0) begin
            home_q <= alt_mm_i;
          end else begin
            rel_alt_q <= {alt_mm_i[31], alt_mm_i} - {home_q[31], home_q};
          end
        end
        gtlo_pkg::FUNC_TGT: begin
          tgt_lat_q <= lat_e7_i;
          tgt_lon_q <= lon_e7_i;
          tgt_alt_q <= alt_mm_i;
          pending_q <= 1'b1;
        end
        gtlo_pkg::FUNC_TICK: pending_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign stat_o.tick_go  = in_valid_i & (func_i == gtlo_pkg::FUNC_TICK) & pending_q;
  assign stat_o.out_free = ~out_valid_o | ~out_stall_i;
  assign stat_o.pending  = pending_q;

  // Differences, folded latitude and vertical offset, captured at start.
  logic [31:0] dlat, lat_ext, lat_abs;
  logic [32:0] dlon;
  logic [30:0] dlat_mag_q;
  logic [31:0] dlon_mag_q;
  logic        dlat_neg_q, dlon_neg_q, flip_q;
  logic [29:0] ang_q;
  logic signed [33:0] down_q;

  assign dlat    = {tgt_lat_q[30], tgt_lat_q} - {cur_lat_q[30], cur_lat_q};
  assign dlon    = {tgt_lon_q[31], tgt_lon_q} - {cur_lon_q[31], cur_lon_q};
  assign lat_ext = {cur_lat_q[30], cur_lat_q};
  assign lat_abs = lat_ext[31] ? (32'd0 - lat_ext) : lat_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dlat_neg_q <= dlat[31];
      dlat_mag_q <= dlat[31] ? 31'(32'd0 - dlat) : dlat[30:0];
      dlon_neg_q <= dlon[32];
      dlon_mag_q <= dlon[32] ? 32'(33'd0 - dlon) : dlon[31:0];
      if (lat_abs[30:0] > gtlo_pkg::QUARTER_E7) begin
        flip_q <= 1'b1;
        ang_q  <= 30'(gtlo_pkg::HALF_E7 - lat_abs[30:0]);
      end else begin
        flip_q <= 1'b0;
        ang_q  <= lat_abs[29:0];
      end
      down_q <= {rel_alt_q[32], rel_alt_q} - {{2{tgt_alt_q[31]}}, tgt_alt_q};
    end
  end

  // Shared 32x32 multiplier with operand selection.
  logic [31:0] a_op, b_op;
  logic [63:0] prod_q;
  logic [55:0] t_q;
  logic [MW-1:0] n_q, e1_q, em_q;
  logic [CM_W-1:0] cm_q;

  always_comb begin
    unique case (cmd_i.op.a)
      gtlo_pkg::A_LAT:  a_op = {2'b0, ang_q};
      gtlo_pkg::A_RAD:  a_op = {9'b0, radius_q};
      gtlo_pkg::A_TLO:  a_op = t_q[31:0];
      gtlo_pkg::A_THI:  a_op = {8'b0, t_q[55:32]};
      gtlo_pkg::A_E1LO: a_op = e1_q[31:0];
      gtlo_pkg::A_E1HI: a_op = {{(64-MW){1'b0}}, e1_q[MW-1:32]};
      default:          a_op = '0;
    endcase
    unique case (cmd_i.op.b)
      gtlo_pkg::B_DEG:  b_op = gtlo_pkg::DEG_TO_RAD;
      gtlo_pkg::B_DLAT: b_op = {1'b0, dlat_mag_q};
      gtlo_pkg::B_DLON: b_op = dlon_mag_q;
      gtlo_pkg::B_KQ:   b_op = gtlo_pkg::KQ_MM;
      gtlo_pkg::B_COS:  b_op = {{(32-CM_W){1'b0}}, cm_q};
      default:          b_op = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= a_op * b_op;
    end
  end

  // Accumulator; a fresh sum starts from its rounding constant.
  logic [AW-1:0] acc_q, acc_d, acc_base, rnd_val, addend;

  always_comb begin
    unique case (cmd_i.op.rnd)
      gtlo_pkg::RND_31: rnd_val = RND31;
      gtlo_pkg::RND_50: rnd_val = RND50;
      gtlo_pkg::RND_F:  rnd_val = RNDF;
      default:          rnd_val = '0;
    endcase
    acc_base = cmd_i.op.clr ? rnd_val : acc_q;
    addend   = cmd_i.op.hi ? {prod_q[55:0], 32'b0} : {24'b0, prod_q};
    acc_d    = acc_base + addend;
  end

  // CORDIC registers.
  logic signed [33:0] x_q, y_q, z_q, dx, dy, atn, cos_r;

  assign dx  = y_q >>> cmd_i.step;
  assign dy  = x_q >>> cmd_i.step;
  assign atn = {2'b0, gtlo_pkg::atan_q30(cmd_i.step)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
      unique case (cmd_i.op.dst)
        gtlo_pkg::DST_T:  t_q  <= acc_d[55:0];
        gtlo_pkg::DST_N:  n_q  <= acc_d[50 +: MW];
        gtlo_pkg::DST_E1: e1_q <= acc_d[50 +: MW];
        gtlo_pkg::DST_EM: em_q <= acc_d[COS_FRAC_BITS +: MW];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && cmd_i.op.dst == gtlo_pkg::DST_Z) begin
      x_q <= gtlo_pkg::CORDIC_GAIN;
      y_q <= '0;
      z_q <= {3'b0, acc_d[61:31]};
    end else if (cmd_i.cordic_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atn;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atn;
      end
    end
  end

  // Round the cosine to its fraction width and clamp to [0, 1].
  assign cos_r = (x_q + COS_RND) >>> SH;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cos_load) begin
      if (cos_r[33]) begin
        cm_q <= '0;
      end else if (cos_r > COS_ONE) begin
        cm_q <= CM_W'(COS_ONE);
      end else begin
        cm_q <= cos_r[CM_W-1:0];
      end
    end
  end

  // Deadband test on the rounded magnitudes and final signs.
  logic        in_db, c_neg;
  logic [19:0] n_sq, e_sq, db_sq;
  logic [20:0] hsum;

  assign n_sq  = n_q[9:0] * n_q[9:0];
  assign e_sq  = em_q[9:0] * em_q[9:0];
  assign db_sq = db_q * db_q;
  assign hsum  = {1'b0, n_sq} + {1'b0, e_sq};
  assign in_db = (n_q < {{(MW-10){1'b0}}, db_q}) && (em_q < {{(MW-10){1'b0}}, db_q})
                 && (hsum < {1'b0, db_sq});
  assign c_neg = flip_q & (cm_q != '0);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (in_db) begin
        north_mm_o <= '0;
        east_mm_o  <= '0;
        down_mm_o  <= '0;
      end else begin
        north_mm_o <= gtlo_pkg::sat36(n_q, dlat_neg_q);
        east_mm_o  <= gtlo_pkg::sat36(em_q, dlon_neg_q ^ c_neg);
        down_mm_o  <= down_q;
      end
    end
  end

endmodule

FILE: rtl/gps_to_local_offset_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_to_local_offset_unit
// Flat-earth north/east/down offset from current position to target.
// ----------------------------------------------------------------------------
// Position and target updates are accepted whenever in_stall_o is low. An
// armed tick passes nine times through the one shared 32x32 multiplier, each
// pass a multiply and an accumulate, and through the CORDIC rotations for the
// cosine of the latitude before its result is loaded. While a tick is being
// worked on, and while its result waits for a free output register, in_stall_o
// is high; a finished result waits in the output register and does not block
// new requests.
module gps_to_local_offset_unit #(
  parameter int unsigned COS_FRAC_BITS = gtlo_pkg::COS_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS  = gtlo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [30:0] lat_e7_i,
  input  logic signed [31:0] lon_e7_i,
  input  logic signed [31:0] alt_mm_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [22:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [35:0] north_mm_o,
  output logic signed [35:0] east_mm_o,
  output logic signed [33:0] down_mm_o
);

  gtlo_pkg::cmd_t  cmd;
  gtlo_pkg::stat_t stat;

  assign in_stall_o = ~cmd.take;

  gtlo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  gtlo_dp #(
    .COS_FRAC_BITS(COS_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .lat_e7_i   (lat_e7_i),
    .lon_e7_i   (lon_e7_i),
    .alt_mm_i   (alt_mm_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .north_mm_o (north_mm_o),
    .east_mm_o  (east_mm_o),
    .down_mm_o  (down_mm_o)
  );

  // An armed tick starts the sequencer and disarms the pending flag.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == gtlo_pkg::FUNC_TICK && stat.pending
    |=> in_stall_o)
    else $error("armed tick did not start the sequencer");

  a_tick_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == gtlo_pkg::FUNC_TICK
    |=> !stat.pending)
    else $error("accepted tick left the pending flag set");

  // A new result only appears at the end of a busy period.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a computation");

endmodule
